/* rtl/aps_pkg.sv */
// ----------------------------------------------------------------------------
// aps_pkg
// Shared types and codes for the AIFF PCM16 stream parser.
// ----------------------------------------------------------------------------
package aps_pkg;

    localparam logic [1:0] KIND_FORMAT = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [1:0] ERR_BAD_TAG    = 2'd0;
    localparam logic [1:0] ERR_BAD_FORMAT = 2'd1;
    localparam logic [1:0] ERR_NO_SSND    = 2'd2;
    localparam logic [1:0] ERR_TRUNCATED  = 2'd3;

    localparam int APS_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
        logic       end_of_stream;
    } aps_in_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] sample_value;
        logic [15:0]        channel_index;
        logic [31:0]        frame_index;
        logic [15:0]        channel_count;
        logic [31:0]        frame_count;
        logic [1:0]         error_code;
    } aps_out_t;

    typedef struct packed {
        logic     valid;
        aps_out_t data;
    } aps_res_t;

endpackage

/* rtl/aps_parse.sv */
// ----------------------------------------------------------------------------
// aps_parse
// Front end: takes one file byte per beat, walks the container and emits
// at most one result record per byte.
// ----------------------------------------------------------------------------
module aps_parse import aps_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  aps_in_t in_beat,
    output aps_res_t res
);

    localparam logic [3:0] PH_FORM      = 4'd0;
    localparam logic [3:0] PH_FSIZE     = 4'd1;
    localparam logic [3:0] PH_AIFF      = 4'd2;
    localparam logic [3:0] PH_CID       = 4'd3;
    localparam logic [3:0] PH_SZ_COMM   = 4'd4;
    localparam logic [3:0] PH_SZ_SSND   = 4'd5;
    localparam logic [3:0] PH_SZ_OTHER  = 4'd6;
    localparam logic [3:0] PH_COMM_CH   = 4'd7;
    localparam logic [3:0] PH_COMM_FR   = 4'd8;
    localparam logic [3:0] PH_COMM_BITS = 4'd9;
    localparam logic [3:0] PH_COMM_RATE = 4'd10;
    localparam logic [3:0] PH_SKIP      = 4'd11;
    localparam logic [3:0] PH_SSND_OFS  = 4'd12;
    localparam logic [3:0] PH_SAMPLE    = 4'd13;
    localparam logic [3:0] PH_FINISH    = 4'd14;
    localparam logic [3:0] PH_IDLE      = 4'd15;

    localparam logic [31:0] TAG_FORM = 32'h464F524D;
    localparam logic [31:0] TAG_AIFF = 32'h41494646;
    localparam logic [31:0] TAG_COMM = 32'h434F4D4D;
    localparam logic [31:0] TAG_SSND = 32'h53534E44;
    localparam logic [15:0] NEEDED_BITS = 16'd16;
    localparam logic [31:0] COMM_FIXED_LEN = 32'd18;

    logic [3:0]  phase_reg,  phase_next;
    logic [3:0]  bif_reg,    bif_next;
    logic [31:0] tag_reg,    tag_next;
    logic [31:0] chunk_reg,  chunk_next;
    logic [32:0] skip_reg,   skip_next;
    logic [15:0] chs_reg,    chs_next;
    logic [31:0] frs_reg,    frs_next;
    logic [15:0] bits_reg,   bits_next;
    logic [15:0] cch_reg,    cch_next;
    logic [31:0] cfr_reg,    cfr_next;
    logic [7:0]  hi_reg,     hi_next;

    function automatic logic field_done(input logic [3:0] cnt, input logic [3:0] n);
        return ({1'b0, cnt} + 5'd1) >= {1'b0, n};
    endfunction

    always_comb begin
        logic        sof;
        logic        has_res;
        logic [1:0]  kind;
        logic [1:0]  err;
        logic [15:0] sval;
        logic [15:0] sch;
        logic [31:0] sfr;
        logic [3:0]  ph;
        logic [3:0]  bif;
        logic [31:0] tag_base;
        logic [31:0] cfr_inc;
        logic [32:0] skip_dec;
        logic [32:0] skip_len;

        sof        = in_beat.start_of_file;
        has_res    = 1'b0;
        kind       = KIND_FORMAT;
        err        = ERR_BAD_TAG;
        sval       = '0;
        sch        = '0;
        sfr        = '0;
        ph         = sof ? PH_FORM : phase_reg;
        bif        = sof ? 4'd0 : bif_reg;
        tag_base   = sof ? 32'd0 : tag_reg;
        chunk_next = sof ? 32'd0 : chunk_reg;
        skip_next  = sof ? 33'd0 : skip_reg;
        chs_next   = sof ? 16'd0 : chs_reg;
        frs_next   = sof ? 32'd0 : frs_reg;
        bits_next  = sof ? 16'd0 : bits_reg;
        cch_next   = sof ? 16'd0 : cch_reg;
        cfr_next   = sof ? 32'd0 : cfr_reg;
        hi_next    = sof ? 8'd0 : hi_reg;
        tag_next   = {tag_base[23:0], in_beat.data_byte};
        phase_next = ph;
        bif_next   = bif;
        cfr_inc    = cfr_next + 32'd1;
        skip_dec   = (skip_next != 33'd0) ? skip_next - 33'd1 : skip_next;
        skip_len   = '0;

        unique case (ph)
            PH_FORM, PH_FSIZE, PH_AIFF, PH_CID, PH_SZ_COMM, PH_SZ_SSND,
            PH_SZ_OTHER, PH_COMM_FR: begin
                if (field_done(bif, 4'd4)) begin
                    bif_next = 4'd0;
                    unique case (ph)
                        PH_FORM: begin
                            if (tag_next == TAG_FORM) begin
                                phase_next = PH_FSIZE;
                            end else begin
                                has_res = 1'b1;
                                kind    = KIND_ERROR;
                                err     = ERR_BAD_TAG;
                            end
                        end
                        PH_FSIZE: phase_next = PH_AIFF;
                        PH_AIFF: begin
                            if (tag_next == TAG_AIFF) begin
                                phase_next = PH_CID;
                            end else begin
                                has_res = 1'b1;
                                kind    = KIND_ERROR;
                                err     = ERR_BAD_TAG;
                            end
                        end
                        PH_CID: begin
                            if (tag_next == TAG_COMM) begin
                                phase_next = PH_SZ_COMM;
                            end else if (tag_next == TAG_SSND) begin
                                phase_next = PH_SZ_SSND;
                            end else begin
                                phase_next = PH_SZ_OTHER;
                            end
                        end
                        PH_SZ_COMM: begin
                            chunk_next = tag_next;
                            phase_next = PH_COMM_CH;
                        end
                        PH_SZ_SSND: begin
                            chunk_next = tag_next;
                            has_res    = 1'b1;
                            if (chs_next == 16'd0 || bits_next != NEEDED_BITS) begin
                                kind = KIND_ERROR;
                                err  = ERR_BAD_FORMAT;
                            end else begin
                                kind       = KIND_FORMAT;
                                phase_next = PH_SSND_OFS;
                            end
                        end
                        PH_SZ_OTHER: begin
                            chunk_next = tag_next;
                            skip_len   = {1'b0, tag_next} + {32'd0, tag_next[0]};
                            skip_next  = skip_len;
                            phase_next = (skip_len != 33'd0) ? PH_SKIP : PH_CID;
                        end
                        default: begin
                            frs_next   = tag_next;
                            phase_next = PH_COMM_BITS;
                        end
                    endcase
                end else begin
                    bif_next = bif + 4'd1;
                end
            end
            PH_COMM_CH, PH_COMM_BITS: begin
                if (field_done(bif, 4'd2)) begin
                    bif_next = 4'd0;
                    if (ph == PH_COMM_CH) begin
                        chs_next   = tag_next[15:0];
                        phase_next = PH_COMM_FR;
                    end else begin
                        bits_next  = tag_next[15:0];
                        phase_next = PH_COMM_RATE;
                    end
                end else begin
                    bif_next = bif + 4'd1;
                end
            end
            PH_COMM_RATE: begin
                if (field_done(bif, 4'd10)) begin
                    bif_next = 4'd0;
                    if (chunk_next > COMM_FIXED_LEN) begin
                        skip_len = {1'b0, chunk_next - COMM_FIXED_LEN}
                                 + {32'd0, chunk_next[0]};
                    end
                    skip_next  = skip_len;
                    phase_next = (skip_len != 33'd0) ? PH_SKIP : PH_CID;
                end else begin
                    bif_next = bif + 4'd1;
                end
            end
            PH_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == 33'd0) begin
                    phase_next = PH_CID;
                end
            end
            PH_SSND_OFS: begin
                if (field_done(bif, 4'd8)) begin
                    bif_next = 4'd0;
                    cch_next = 16'd0;
                    cfr_next = 32'd0;
                    if (frs_next == 32'd0) begin
                        has_res    = 1'b1;
                        kind       = KIND_DONE;
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_SAMPLE;
                    end
                end else begin
                    bif_next = bif + 4'd1;
                end
            end
            PH_SAMPLE: begin
                if (bif == 4'd0) begin
                    hi_next  = in_beat.data_byte;
                    bif_next = 4'd1;
                end else begin
                    bif_next = 4'd0;
                    has_res  = 1'b1;
                    kind     = KIND_SAMPLE;
                    sval     = {hi_next, in_beat.data_byte};
                    sch      = cch_next;
                    sfr      = cfr_next;
                    if (({1'b0, cch_next} + 17'd1) >= {1'b0, chs_next}) begin
                        cch_next = 16'd0;
                        cfr_next = cfr_inc;
                        if (cfr_inc == frs_next) begin
                            phase_next = PH_FINISH;
                        end
                    end else begin
                        cch_next = cch_next + 16'd1;
                    end
                end
            end
            PH_FINISH: begin
                has_res    = 1'b1;
                kind       = KIND_DONE;
                phase_next = PH_IDLE;
            end
            default: begin
            end
        endcase

        if (has_res && kind == KIND_ERROR) begin
            phase_next = PH_IDLE;
        end

        if (in_beat.end_of_stream) begin
            if (!(has_res && kind == KIND_ERROR) && phase_next != PH_FINISH
                    && phase_next != PH_IDLE) begin
                has_res = 1'b1;
                kind    = KIND_ERROR;
                err     = (phase_next == PH_SSND_OFS || phase_next == PH_SAMPLE)
                        ? ERR_TRUNCATED : ERR_NO_SSND;
                sval    = '0;
                sch     = '0;
                sfr     = '0;
            end
            phase_next = PH_IDLE;
        end

        res.valid              = fire && has_res;
        res.data.kind          = kind;
        res.data.sample_value  = (kind == KIND_SAMPLE) ? sval : 16'sd0;
        res.data.channel_index = (kind == KIND_SAMPLE) ? sch : 16'd0;
        res.data.frame_index   = (kind == KIND_SAMPLE) ? sfr : 32'd0;
        res.data.channel_count = chs_next;
        res.data.frame_count   = frs_next;
        res.data.error_code    = (kind == KIND_ERROR) ? err : ERR_BAD_TAG;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FORM;
            bif_reg   <= '0;
            tag_reg   <= '0;
            chunk_reg <= '0;
            skip_reg  <= '0;
            chs_reg   <= '0;
            frs_reg   <= '0;
            bits_reg  <= '0;
            cch_reg   <= '0;
            cfr_reg   <= '0;
            hi_reg    <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            bif_reg   <= bif_next;
            tag_reg   <= tag_next;
            chunk_reg <= chunk_next;
            skip_reg  <= skip_next;
            chs_reg   <= chs_next;
            frs_reg   <= frs_next;
            bits_reg  <= bits_next;
            cch_reg   <= cch_next;
            cfr_reg   <= cfr_next;
            hi_reg    <= hi_next;
        end
    end

    // an error always parks the parser
    assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && res.data.kind == KIND_ERROR |=> phase_reg == PH_IDLE)
        else $error("parser not idle after error");

    // a sample only completes on the low byte of a word in the sample phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && res.data.kind == KIND_SAMPLE |->
            !in_beat.start_of_file && phase_reg == PH_SAMPLE && bif_reg == 4'd1)
        else $error("sample emitted outside sample phase");

    // a format record moves the parser on to the sound header
    assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && res.data.kind == KIND_FORMAT |=> phase_reg == PH_SSND_OFS)
        else $error("parser not at sound header after format record");

endmodule

/* rtl/aps_fifo.sv */
// ----------------------------------------------------------------------------
// aps_fifo
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module aps_fifo import aps_pkg::*; #(
    parameter int DEPTH = APS_QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  aps_res_t wr,
    output logic     full,
    output logic     rd_valid,
    output aps_out_t rd_data,
    input  logic     rd_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aps_out_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic               push;

    assign push     = wr.valid;
    assign full     = cnt_reg == CNT_W'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({push, rd_pop})
            2'b10:   cnt_next = cnt_reg + CNT_W'(1);
            2'b01:   cnt_next = cnt_reg - CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !full)
        else $error("queue overflow");

    assert property (@(posedge aclk) disable iff (!aresetn) rd_pop |-> rd_valid)
        else $error("queue underflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push && !rd_pop |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("queue count lost a push");

endmodule

/* rtl/aps_out.sv */
// ----------------------------------------------------------------------------
// aps_out
// Output register: presents the queue head on the result channel.
// ----------------------------------------------------------------------------
module aps_out import aps_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     head_valid,
    input  aps_out_t head_data,
    output logic     head_pop,
    output logic     m_valid,
    input  logic     m_ready,
    output aps_out_t m_data
);

    logic     valid_reg, valid_next;
    aps_out_t data_reg;

    assign head_pop   = head_valid && (!valid_reg || m_ready);
    assign valid_next = head_pop || (valid_reg && !m_ready);
    assign m_valid    = valid_reg;
    assign m_data     = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (head_pop) begin
            data_reg <= head_data;
        end
    end

endmodule

/* rtl/aiff_pcm16_stream_parser_unit.sv */
// ----------------------------------------------------------------------------
// aiff_pcm16_stream_parser_unit
// AIFF container parser: one byte per beat in, format/sample/done/error
// records out.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while s_ready is high; the parser updates its phase once per byte.
// A result is queued when its byte is accepted and is then loaded into the output
//   register once that register is empty or its record is being taken on m_.
// The result queue holds QUEUE_DEPTH records; s_ready drops only when it is full.
// Reset (aresetn low, synchronous) returns the parser to the FORM tag and
//   empties the queue and the output register.
module aiff_pcm16_stream_parser_unit import aps_pkg::*; #(
    parameter int QUEUE_DEPTH = APS_QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  aps_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output aps_out_t m_data
);

    logic     fire;
    logic     q_full;
    logic     head_valid;
    logic     head_pop;
    aps_out_t head_data;
    aps_res_t res;

    assign s_ready = !q_full;
    assign fire    = s_valid && s_ready;

    aps_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .in_beat (s_data),
        .res     (res)
    );

    aps_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (res),
        .full     (q_full),
        .rd_valid (head_valid),
        .rd_data  (head_data),
        .rd_pop   (head_pop)
    );

    aps_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_data  (head_data),
        .head_pop   (head_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

/* tb/tb_aiff_pcm16_stream_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aiff_pcm16_stream_parser_unit
// Feeds AIFF byte streams into the parser and checks every output record.
// A short table of hand-built beats comes first, then files of fixed shape, then
// random files (well-formed, broken, cut short, pure noise). A parser model in the
// bench predicts each record, save where a table row fixes it; each record is compared
// field by field with the oldest one due. Both channels idle at random but in the last run.
// ----------------------------------------------------------------------------
module tb_aiff_pcm16_stream_parser_unit;
    import aps_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 16;
    localparam int MAX_SAMPLES = 32;
    localparam int COMM_BODY   = 18;
    localparam int PCM_BITS    = 16;

    localparam logic [31:0] TAG_FORM = 32'h464F524D;
    localparam logic [31:0] TAG_AIFF = 32'h41494646;
    localparam logic [31:0] TAG_COMM = 32'h434F4D4D;
    localparam logic [31:0] TAG_SSND = 32'h53534E44;

    typedef enum logic [3:0] {
        ST_FORM, ST_FORM_SIZE, ST_AIFF, ST_CHUNK_ID, ST_LEN_COMM, ST_LEN_SSND,
        ST_LEN_OTHER, ST_COMM_CH, ST_COMM_FRAMES, ST_COMM_BITS, ST_COMM_RATE,
        ST_SKIP, ST_SSND_HDR, ST_SAMPLE, ST_FINISH, ST_IDLE
    } parse_st_t;

    typedef enum int {
        END_DONE, END_LAST_SAMPLE, END_CUT, END_CUT_LATE, END_OPEN
    } file_end_t;

    typedef struct {
        aps_in_t  beat;
        bit       fixed;
        bit       fixed_has;
        aps_out_t fixed_rec;
    } dir_row_t;

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    aps_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    aps_out_t m_data;

    aiff_pcm16_stream_parser_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // parser model state
    parse_st_t   parse_st;
    logic [3:0]  fld_pos;
    logic [31:0] shift_reg;
    logic [31:0] chunk_len;
    logic [32:0] skip_left;
    logic [15:0] chans_seen;
    logic [31:0] frames_seen;
    logic [15:0] depth_seen;
    logic [15:0] cur_ch;
    logic [31:0] cur_fr;
    logic [7:0]  hi_byte;

    aps_out_t    due_records[$];
    aps_out_t    head_rec;
    aps_in_t     file_beats[$];
    dir_row_t    dir_table[$];
    int unsigned live_bytes;
    int unsigned mismatches;
    int unsigned stall_cycles;
    int unsigned feed_idle_pct;
    int unsigned drain_idle_pct;

    function automatic void clear_parser();
        parse_st    = ST_FORM;
        fld_pos     = '0;
        shift_reg   = '0;
        chunk_len   = '0;
        skip_left   = '0;
        chans_seen  = '0;
        frames_seen = '0;
        depth_seen  = '0;
        cur_ch      = '0;
        cur_fr      = '0;
        hi_byte     = '0;
    endfunction

    function automatic bit field_done(input int unsigned len);
        if (32'(fld_pos) + 32'd1 >= len) begin
            fld_pos = '0;
            return 1'b1;
        end
        fld_pos = fld_pos + 4'd1;
        return 1'b0;
    endfunction

    function automatic void enter_skip(input logic [32:0] n);
        skip_left = n;
        parse_st  = (n != '0) ? ST_SKIP : ST_CHUNK_ID;
    endfunction

    // Advances the model by one byte; returns 1 when the byte yields a record.
    function automatic bit parse_byte(input aps_in_t beat, output aps_out_t rec);
        bit         has;
        logic [7:0] b;
        has = 1'b0;
        rec = '0;
        b   = beat.data_byte;
        if (beat.start_of_file) clear_parser();
        live_bytes++;
        shift_reg = {shift_reg[23:0], b};
        case (parse_st)
            ST_FORM: begin
                if (field_done(4)) begin
                    if (shift_reg == TAG_FORM) begin
                        parse_st = ST_FORM_SIZE;
                    end else begin
                        has = 1'b1;
                        rec.kind = KIND_ERROR;
                        rec.error_code = ERR_BAD_TAG;
                    end
                end
            end
            ST_FORM_SIZE: begin
                if (field_done(4)) parse_st = ST_AIFF;
            end
            ST_AIFF: begin
                if (field_done(4)) begin
                    if (shift_reg == TAG_AIFF) begin
                        parse_st = ST_CHUNK_ID;
                    end else begin
                        has = 1'b1;
                        rec.kind = KIND_ERROR;
                        rec.error_code = ERR_BAD_TAG;
                    end
                end
            end
            ST_CHUNK_ID: begin
                if (field_done(4)) begin
                    if (shift_reg == TAG_COMM) parse_st = ST_LEN_COMM;
                    else if (shift_reg == TAG_SSND) parse_st = ST_LEN_SSND;
                    else parse_st = ST_LEN_OTHER;
                end
            end
            ST_LEN_COMM: begin
                if (field_done(4)) begin
                    chunk_len = shift_reg;
                    parse_st = ST_COMM_CH;
                end
            end
            ST_LEN_OTHER: begin
                if (field_done(4)) begin
                    chunk_len = shift_reg;
                    enter_skip({1'b0, chunk_len} + chunk_len[0]);
                end
            end
            ST_LEN_SSND: begin
                if (field_done(4)) begin
                    chunk_len = shift_reg;
                    has = 1'b1;
                    if (chans_seen == '0 || depth_seen != 16'(PCM_BITS)) begin
                        rec.kind = KIND_ERROR;
                        rec.error_code = ERR_BAD_FORMAT;
                    end else begin
                        rec.kind = KIND_FORMAT;
                        parse_st = ST_SSND_HDR;
                    end
                end
            end
            ST_COMM_CH: begin
                if (field_done(2)) begin
                    chans_seen = shift_reg[15:0];
                    parse_st = ST_COMM_FRAMES;
                end
            end
            ST_COMM_FRAMES: begin
                if (field_done(4)) begin
                    frames_seen = shift_reg;
                    parse_st = ST_COMM_BITS;
                end
            end
            ST_COMM_BITS: begin
                if (field_done(2)) begin
                    depth_seen = shift_reg[15:0];
                    parse_st = ST_COMM_RATE;
                end
            end
            ST_COMM_RATE: begin
                if (field_done(10)) begin
                    if (chunk_len > 32'(COMM_BODY))
                        enter_skip({1'b0, chunk_len - 32'(COMM_BODY)} + chunk_len[0]);
                    else
                        enter_skip('0);
                end
            end
            ST_SKIP: begin
                if (skip_left != '0) skip_left = skip_left - 33'd1;
                if (skip_left == '0) parse_st = ST_CHUNK_ID;
            end
            ST_SSND_HDR: begin
                if (field_done(8)) begin
                    cur_ch = '0;
                    cur_fr = '0;
                    if (frames_seen == '0) begin
                        has = 1'b1;
                        rec.kind = KIND_DONE;
                        parse_st = ST_IDLE;
                    end else begin
                        parse_st = ST_SAMPLE;
                    end
                end
            end
            ST_SAMPLE: begin
                if (fld_pos == 4'd0) begin
                    hi_byte = b;
                    fld_pos = 4'd1;
                end else begin
                    fld_pos = 4'd0;
                    has = 1'b1;
                    rec.kind = KIND_SAMPLE;
                    rec.sample_value = {hi_byte, b};
                    rec.channel_index = cur_ch;
                    rec.frame_index = cur_fr;
                    if (32'(cur_ch) + 32'd1 >= 32'(chans_seen)) begin
                        cur_ch = '0;
                        cur_fr = cur_fr + 32'd1;
                        if (cur_fr == frames_seen) parse_st = ST_FINISH;
                    end else begin
                        cur_ch = cur_ch + 16'd1;
                    end
                end
            end
            ST_FINISH: begin
                has = 1'b1;
                rec.kind = KIND_DONE;
                parse_st = ST_IDLE;
            end
            default: ;
        endcase

        if (has && rec.kind == KIND_ERROR) parse_st = ST_IDLE;

        if (beat.end_of_stream) begin
            if (!(has && rec.kind == KIND_ERROR) && parse_st != ST_FINISH
                    && parse_st != ST_IDLE) begin
                has = 1'b1;
                rec = '0;
                rec.kind = KIND_ERROR;
                rec.error_code = (parse_st == ST_SSND_HDR || parse_st == ST_SAMPLE)
                                 ? ERR_TRUNCATED : ERR_NO_SSND;
            end
            parse_st = ST_IDLE;
        end

        rec.channel_count = chans_seen;
        rec.frame_count   = frames_seen;
        return has;
    endfunction

    function automatic void queue_prediction(input aps_in_t beat);
        aps_out_t rec;
        if (parse_byte(beat, rec)) due_records.push_back(rec);
    endfunction

    // ---------------- record checking ----------------
    function automatic void check_field(input string fname, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, fname, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_records.size() == 0) begin
                $display("%0t ns: unexpected record, expected none, got kind %0d",
                         $time, m_data.kind);
                mismatches++;
            end else begin
                head_rec = due_records.pop_front();
                check_field("kind", 32'(head_rec.kind), 32'(m_data.kind));
                check_field("sample_value", 32'(head_rec.sample_value),
                            32'(m_data.sample_value));
                check_field("channel_index", 32'(head_rec.channel_index),
                            32'(m_data.channel_index));
                check_field("frame_index", head_rec.frame_index, m_data.frame_index);
                check_field("channel_count", 32'(head_rec.channel_count),
                            32'(m_data.channel_count));
                check_field("frame_count", head_rec.frame_count, m_data.frame_count);
                check_field("error_code", 32'(head_rec.error_code),
                            32'(m_data.error_code));
            end
        end
        m_ready <= (drain_idle_pct == 0) || ($urandom_range(99) >= drain_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------- beat driving ----------------
    task automatic send_beat(input aps_in_t beat);
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic feed_gap();
        if (feed_idle_pct != 0 && $urandom_range(99) < feed_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < feed_idle_pct);
        end
    endtask

    task automatic wait_all_records();
        s_valid <= 1'b0;
        do @(posedge aclk); while (due_records.size() != 0);
    endtask

    // ---------------- file building ----------------
    function automatic void put_byte(input logic [7:0] b);
        aps_in_t beat;
        beat = '0;
        beat.data_byte = b;
        file_beats.push_back(beat);
    endfunction

    function automatic void put_word(input logic [31:0] w, input int nbytes);
        for (int i = nbytes - 1; i >= 0; i--) put_byte(w[8*i +: 8]);
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_file();
        for (int i = 0; i < file_beats.size(); i++) begin
            send_beat(file_beats[i]);
            queue_prediction(file_beats[i]);
            feed_gap();
        end
    endtask

    task automatic stream_file(input bit bad_form, input bit bad_aiff, input int n_other,
                               input int comm_copies, input logic [31:0] comm_len,
                               input logic [15:0] chans, input logic [31:0] frames,
                               input logic [15:0] bits, input bit with_ssnd,
                               input file_end_t how);
        int unsigned     n_samples;
        int unsigned     ssnd_at;
        int unsigned     cut;
        int unsigned     len;
        longint unsigned total;
        logic [31:0]     id;
        file_end_t       mode;
        file_beats.delete();
        mode = how;
        put_word(bad_form ? TAG_FORM ^ (32'd1 << $urandom_range(31)) : TAG_FORM, 4);
        put_word($urandom, 4);
        put_word(bad_aiff ? TAG_AIFF ^ (32'd1 << $urandom_range(31)) : TAG_AIFF, 4);
        for (int i = 0; i < n_other; i++) begin
            do id = $urandom; while (id == TAG_COMM || id == TAG_SSND);
            len = $urandom_range(7);
            put_word(id, 4);
            put_word(len, 4);
            repeat (len + len % 2) put_byte(8'($urandom));
        end
        for (int i = 0; i < comm_copies; i++) begin
            put_word(TAG_COMM, 4);
            put_word(comm_len, 4);
            if (i + 1 < comm_copies) begin
                put_word($urandom, 2);
                put_word($urandom, 4);
                put_word($urandom, 2);
            end else begin
                put_word(chans, 2);
                put_word(frames, 4);
                put_word(bits, 2);
            end
            repeat (10) put_byte(8'($urandom));
            if (comm_len > 32'(COMM_BODY))
                repeat (comm_len - 32'(COMM_BODY) + comm_len[0]) put_byte(8'($urandom));
        end
        ssnd_at = file_beats.size();
        if (with_ssnd) begin
            put_word(TAG_SSND, 4);
            put_word($urandom, 4);
            ssnd_at = file_beats.size();
            repeat (8) put_byte(8'($urandom));
            total = longint'(chans) * longint'(frames);
            if (total > MAX_SAMPLES) begin
                n_samples = MAX_SAMPLES;
                if (mode != END_CUT) mode = END_CUT_LATE;
            end else begin
                n_samples = int'(total);
            end
            repeat (n_samples) put_word(pick_sample(), 2);
        end
        case (mode)
            END_LAST_SAMPLE: ;
            END_CUT, END_CUT_LATE: begin
                if (mode == END_CUT || ssnd_at >= file_beats.size())
                    cut = $urandom_range(file_beats.size() - 1);
                else
                    cut = $urandom_range(file_beats.size() - 1, ssnd_at);
                while (file_beats.size() > cut + 1) void'(file_beats.pop_back());
            end
            default: begin
                repeat ($urandom_range(4, 1)) put_byte(8'($urandom));
            end
        endcase
        file_beats[0].start_of_file = 1'b1;
        if (mode != END_OPEN && !(mode == END_CUT && $urandom_range(3) == 0))
            file_beats[file_beats.size() - 1].end_of_stream = 1'b1;
        send_file();
    endtask

    task automatic stream_noise();
        int unsigned n;
        file_beats.delete();
        if ($urandom_range(1)) put_word(TAG_FORM, 4);
        n = $urandom_range(24, 1);
        repeat (n) put_byte(8'($urandom));
        if ($urandom_range(3) != 0) file_beats[0].start_of_file = 1'b1;
        if ($urandom_range(1)) file_beats[file_beats.size() - 1].end_of_stream = 1'b1;
        send_file();
    endtask

    task automatic stream_random_file();
        int unsigned r;
        int          copies;
        logic [31:0] clen;
        logic [15:0] ch;
        logic [31:0] fr;
        logic [15:0] depth;
        file_end_t   how;
        if ($urandom_range(99) < 10) begin
            stream_noise();
            return;
        end
        r = $urandom_range(99);
        copies = (r < 5) ? 0 : (r < 15) ? 2 : 1;
        r = $urandom_range(99);
        clen = (r < 70) ? 32'(COMM_BODY) : (r < 90) ? $urandom_range(26, 19)
                                                    : $urandom_range(17);
        r = $urandom_range(99);
        ch = (r < 80) ? 16'($urandom_range(4, 1)) : (r < 92) ? 16'($urandom) : 16'd0;
        fr = ($urandom_range(99) < 88) ? $urandom_range(5) : $urandom;
        depth = ($urandom_range(99) < 90) ? 16'(PCM_BITS) : 16'($urandom);
        r = $urandom_range(99);
        how = (r < 50) ? END_DONE : (r < 65) ? END_LAST_SAMPLE : (r < 78) ? END_CUT
            : (r < 90) ? END_CUT_LATE : END_OPEN;
        stream_file($urandom_range(99) < 3, $urandom_range(99) < 3, $urandom_range(2),
                    copies, clen, ch, fr, depth, $urandom_range(99) < 95, how);
    endtask

    function automatic void add_row(input logic [7:0] b, input bit sof, input bit eos,
                                    input bit fixed = 1'b0, input bit has = 1'b0,
                                    input logic [1:0] code = ERR_BAD_TAG);
        dir_row_t row;
        row.beat = '0;
        row.beat.data_byte = b;
        row.beat.start_of_file = sof;
        row.beat.end_of_stream = eos;
        row.fixed = fixed;
        row.fixed_has = has;
        row.fixed_rec = '0;
        row.fixed_rec.kind = KIND_ERROR;
        row.fixed_rec.error_code = code;
        dir_table.push_back(row);
    endfunction

    initial begin
        aps_out_t rec;
        bit       has;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        live_bytes     = 0;
        mismatches     = 0;
        stall_cycles   = 0;
        feed_idle_pct  = 16;
        drain_idle_pct = 55;
        clear_parser();

        // single byte that is both first and last
        add_row(8'h00, 1'b1, 1'b1, 1'b1, 1'b1, ERR_NO_SSND);
        // bad FORM tag, then a byte that must be ignored
        add_row("F", 1'b1, 1'b0);
        add_row("O", 1'b0, 1'b0);
        add_row("R", 1'b0, 1'b0);
        add_row(8'hFF, 1'b0, 1'b0, 1'b1, 1'b1, ERR_BAD_TAG);
        add_row(8'h55, 1'b0, 1'b1, 1'b1, 1'b0);
        // good FORM, bad AIFF tag
        add_row("F", 1'b1, 1'b0);
        add_row("O", 1'b0, 1'b0);
        add_row("R", 1'b0, 1'b0);
        add_row("M", 1'b0, 1'b0);
        add_row(8'hFF, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0);
        add_row(8'hFF, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0);
        add_row("A", 1'b0, 1'b0);
        add_row("I", 1'b0, 1'b0);
        add_row("F", 1'b0, 1'b0);
        add_row("X", 1'b0, 1'b0, 1'b1, 1'b1, ERR_BAD_TAG);
        // end of stream inside the FORM tag
        add_row("F", 1'b1, 1'b0);
        add_row("O", 1'b0, 1'b1, 1'b1, 1'b1, ERR_NO_SSND);
        add_row(8'hAA, 1'b0, 1'b0, 1'b1, 1'b0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_table[i]) begin
            send_beat(dir_table[i].beat);
            has = parse_byte(dir_table[i].beat, rec);
            if (dir_table[i].fixed) begin
                if (dir_table[i].fixed_has) due_records.push_back(dir_table[i].fixed_rec);
            end else if (has) begin
                due_records.push_back(rec);
            end
            feed_gap();
        end

        stream_file(0, 0, 1, 1, 18, 16'd2, 32'd3, 16'd16, 1, END_DONE);
        stream_file(0, 0, 0, 1, 21, 16'd1, 32'd2, 16'd16, 1, END_LAST_SAMPLE);
        stream_file(0, 0, 2, 1, 4, 16'd3, 32'd1, 16'd16, 1, END_DONE);
        stream_file(0, 0, 0, 2, 18, 16'd1, 32'd1, 16'd16, 1, END_DONE);
        stream_file(0, 0, 0, 1, 18, 16'hFFFF, 32'd0, 16'd16, 1, END_DONE);
        stream_file(0, 0, 0, 1, 18, 16'd1, 32'd1, 16'd8, 1, END_DONE);
        stream_file(0, 0, 1, 0, 18, 16'd0, 32'd0, 16'd16, 1, END_DONE);
        stream_file(0, 0, 1, 1, 18, 16'd1, 32'd1, 16'd16, 0, END_DONE);
        stream_file(0, 0, 0, 1, 18, 16'd1, 32'hFFFF_FFFF, 16'd16, 1, END_CUT_LATE);
        stream_file(0, 0, 0, 1, 19, 16'd2, 32'd2, 16'd16, 1, END_OPEN);

        while (live_bytes < 400) stream_random_file();
        wait_all_records();

        feed_idle_pct  = 55;
        drain_idle_pct = 16;
        while (live_bytes < 800) stream_random_file();
        wait_all_records();

        feed_idle_pct  = 0;
        drain_idle_pct = 0;
        while (live_bytes < 1150) stream_random_file();
        wait_all_records();

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0 && due_records.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/aps_pkg.sv
rtl/aps_parse.sv
rtl/aps_fifo.sv
rtl/aps_out.sv
rtl/aiff_pcm16_stream_parser_unit.sv
tb/tb_aiff_pcm16_stream_parser_unit.sv
